// ===== design/ipv4_fragment_reassembly_tracker_assert.svh =====
// Assertion macros for the fragment reassembly tracker.
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
// Implication checked every cycle outside reset.
`define FRT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define FRT_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== design/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// frt_pkg
// Shared constants and types for the fragment reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package frt_pkg;
  localparam int NUM_SLOTS       = 4;
  localparam int BUF_BYTES       = 8192;
  localparam int CHUNKS          = (BUF_BYTES + 7) / 8;
  localparam int WORDS           = (CHUNKS + 31) / 32;
  localparam int SLOT_W          = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WORD_W          = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MEM_DEPTH       = NUM_SLOTS * WORDS;
  localparam int MEM_AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LEN_W           = 14;
  localparam int OPLEN_W         = 17;
  localparam logic [31:0] LIFETIME_RESET = 32'd5000000;

  localparam logic [2:0] ST_WAIT  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_AGED  = 3'd4;

  localparam logic OP_FRAG = 1'b0;
  localparam logic OP_AGE  = 1'b1;

  typedef struct packed {
    logic [2:0]       status;
    logic [1:0]       slot_index;
    logic [LEN_W-1:0] dgram_len;
  } frt_result_t;
endpackage
`default_nettype wire

// ===== design/frt_ifc.sv =====
// ----------------------------------------------------------------------------
// frt_ifc
// Valid/ready channels for requests, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none
interface frt_in_ifc;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] ident;
  logic [7:0]  proto_num;
  logic [12:0] frag_offset;
  logic [15:0] frag_bytes;
  logic        mf_flag;
  logic [63:0] now_us;
  modport source (output valid, opcode, src_addr, dst_addr, ident, proto_num,
                  frag_offset, frag_bytes, mf_flag, now_us, input ready);
  modport sink (input valid, opcode, src_addr, dst_addr, ident, proto_num,
                frag_offset, frag_bytes, mf_flag, now_us, output ready);
endinterface

interface frt_out_ifc;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  slot_index;
  logic [13:0] dgram_len;
  modport source (output valid, status, slot_index, dgram_len, input ready);
  modport sink (input valid, status, slot_index, dgram_len, output ready);
endinterface

interface frt_cfg_ifc;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/ipv4_fragment_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker
// Tracks IPv4 fragment arrival per datagram in chunk bitmaps.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when the block is idle and the
// result register is empty or being drained. An age tick runs one shared
// 64-bit compare per slot. A fragment takes a key search of one slot per
// cycle, then a walk over the slot's bitmap words through one read port and
// one write port: the mark pass reads, waits for and writes back each word,
// and the completion pass reads and checks each needed word. Newly taken
// slots are cleared word by word before marking. The bitmap is not cleared
// at reset: a slot's words are zeroed each time the slot is taken.
`default_nettype none
module ipv4_fragment_reassembly_tracker (
  input wire logic  clk,
  input wire logic  rst_n,
  frt_in_ifc.sink   in_ch,
  frt_out_ifc.source out_ch,
  frt_cfg_ifc.sink  cfg_ch
);
  import frt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_AGE   = 9'b000000010,
    S_FIND  = 9'b000000100,
    S_CLR   = 9'b000001000,
    S_MRD   = 9'b000010000,
    S_MWAIT = 9'b000100000,
    S_MWR   = 9'b001000000,
    S_CRD   = 9'b010000000,
    S_CCHK  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  logic [31:0] src_r, dst_r;
  logic [15:0] id_r;
  logic [7:0]  pr_r;
  logic [12:0] off_r;
  logic [15:0] plen_r;
  logic        mf_r;
  logic [63:0] now_r;

  logic [31:0] lifetime_r;

  // Slot table.
  logic [NUM_SLOTS-1:0] live_r;
  logic [31:0]      s_src_r [NUM_SLOTS];
  logic [31:0]      s_dst_r [NUM_SLOTS];
  logic [15:0]      s_id_r  [NUM_SLOTS];
  logic [7:0]       s_pr_r  [NUM_SLOTS];
  logic [63:0]      s_exp_r [NUM_SLOTS];
  logic [LEN_W-1:0] s_len_r [NUM_SLOTS];

  logic [SLOT_W:0]   scan_r;      // slot scan counter
  logic [SLOT_W-1:0] hit_r;
  logic              hit_ok_r;
  logic              free_ok_r;
  logic [SLOT_W-1:0] free_r;
  logic [WORD_W:0]   word_r;      // bitmap word counter
  logic [LEN_W-1:0]  len_r;

  // Chunk range of this fragment: [first, last_excl).
  logic [OPLEN_W-1:0] byte_end;
  logic [13:0]        last_excl;
  logic [WORD_W:0]    need_words;

  frt_result_t res_r;
  logic        out_valid_r;

  logic              in_fire;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic [SLOT_W-1:0] scan_idx;
  logic [WORD_W-1:0] word_idx;
  logic              key_eq;
  logic              expired;
  logic [31:0]       chunk_mask;
  logic [31:0]       need_mask;
  logic [13:0]       need_chunks;

  assign in_ch.ready  = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = res_r.status;
  assign out_ch.slot_index = res_r.slot_index;
  assign out_ch.dgram_len  = res_r.dgram_len;

  assign scan_idx = scan_r[SLOT_W-1:0];
  assign word_idx = word_r[WORD_W-1:0];

  // Shared compare unit: key match and expiry check for the scanned slot.
  assign key_eq = live_r[scan_idx] && s_src_r[scan_idx] == src_r &&
                  s_dst_r[scan_idx] == dst_r && s_id_r[scan_idx] == id_r &&
                  s_pr_r[scan_idx] == pr_r;
  assign expired = s_exp_r[scan_idx] <= now_r;

  assign byte_end   = {1'b0, off_r, 3'b000} + {1'b0, plen_r};
  assign last_excl  = 14'({1'b0, off_r}) + 14'((17'(plen_r) + 17'd7) >> 3);
  assign need_chunks = 14'((15'(len_r) + 15'd7) >> 3);
  assign need_words = (WORD_W+1)'((need_chunks + 14'd31) >> 5);

  // Bits of the current word covered by this fragment, and needed for done.
  always_comb begin
    logic [13:0] base;
    base = 14'(word_idx) << 5;
    for (int b = 0; b < 32; b++) begin
      chunk_mask[b] = ((base + 14'(b)) >= 14'(off_r)) &&
                      ((base + 14'(b)) < last_excl);
      need_mask[b]  = (base + 14'(b)) < need_chunks;
    end
  end

  // Bitmap port: clear and mark writes, walk reads.
  always_comb begin
    ram_raddr = MEM_AW'(hit_r) * MEM_AW'(WORDS) + MEM_AW'(word_idx);
    ram_waddr = ram_raddr;
    ram_we    = 1'b0;
    ram_wdata = 32'd0;
    if (state_r == S_CLR) ram_we = 1'b1;
    if (state_r == S_MWR) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata | chunk_mask;
    end
  end

  frt_bitmap_ram #(.DEPTH(MEM_DEPTH), .AW(MEM_AW)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = (in_ch.opcode == OP_AGE) ? S_AGE : S_FIND;
      S_AGE:   if (scan_r == (SLOT_W+1)'(NUM_SLOTS - 1)) state_nxt = S_IDLE;
      S_FIND:  if (byte_end > OPLEN_W'(BUF_BYTES)) state_nxt = S_IDLE;
               else if (hit_ok_r) state_nxt = S_MRD;
               else if (scan_r == (SLOT_W+1)'(NUM_SLOTS)) begin
                 state_nxt = free_ok_r ? S_CLR : S_IDLE;
               end
      S_CLR:   if (word_r == (WORD_W+1)'(WORDS - 1)) state_nxt = S_MRD;
      S_MRD:   state_nxt = S_MWAIT;
      S_MWAIT: state_nxt = S_MWR;
      S_MWR:   if (word_r == (WORD_W+1)'(WORDS - 1)) state_nxt = S_CRD;
               else state_nxt = S_MRD;
      S_CRD:   state_nxt = S_CCHK;
      S_CCHK:  if (len_r == '0 || (ram_rdata & need_mask) != need_mask ||
                   word_r + 1'b1 >= need_words) state_nxt = S_IDLE;
               else state_nxt = S_CRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      lifetime_r  <= LIFETIME_RESET;
      scan_r      <= '0;
      word_r      <= '0;
      hit_ok_r    <= 1'b0;
      free_ok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) lifetime_r <= cfg_ch.data;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            src_r  <= in_ch.src_addr;
            dst_r  <= in_ch.dst_addr;
            id_r   <= in_ch.ident;
            pr_r   <= in_ch.proto_num;
            off_r  <= in_ch.frag_offset;
            plen_r <= in_ch.frag_bytes;
            mf_r   <= in_ch.mf_flag;
            now_r  <= in_ch.now_us;
            scan_r    <= '0;
            word_r    <= '0;
            hit_ok_r  <= 1'b0;
            free_ok_r <= 1'b0;
          end
        end
        S_AGE: begin
          // Free one expired slot per cycle.
          if (live_r[scan_idx] && expired) live_r[scan_idx] <= 1'b0;
          scan_r <= scan_r + 1'b1;
          if (scan_r == (SLOT_W+1)'(NUM_SLOTS - 1)) begin
            res_r       <= '{ST_AGED, 2'd0, '0};
            out_valid_r <= 1'b1;
          end
        end
        S_FIND: begin
          if (byte_end > OPLEN_W'(BUF_BYTES)) begin
            res_r       <= '{ST_RANGE, 2'd0, '0};
            out_valid_r <= 1'b1;
          end else if (hit_ok_r) begin
            len_r <= s_len_r[hit_r];
          end else if (scan_r == (SLOT_W+1)'(NUM_SLOTS)) begin
            if (free_ok_r) begin
              hit_r              <= free_r;
              live_r[free_r]     <= 1'b1;
              s_src_r[free_r]    <= src_r;
              s_dst_r[free_r]    <= dst_r;
              s_id_r[free_r]     <= id_r;
              s_pr_r[free_r]     <= pr_r;
              s_exp_r[free_r]    <= now_r + 64'(lifetime_r);
              s_len_r[free_r]    <= '0;
              len_r              <= '0;
            end else begin
              res_r       <= '{ST_FULL, 2'd0, '0};
              out_valid_r <= 1'b1;
            end
          end else begin
            // Compare one slot per cycle; remember first free slot.
            if (key_eq) begin
              hit_ok_r <= 1'b1;
              hit_r    <= scan_idx;
            end
            if (!live_r[scan_idx] && !free_ok_r) begin
              free_ok_r <= 1'b1;
              free_r    <= scan_idx;
            end
            scan_r <= scan_r + 1'b1;
          end
        end
        S_CLR: begin
          word_r <= (word_r == (WORD_W+1)'(WORDS - 1)) ? '0 : word_r + 1'b1;
        end
        S_MWR: begin
          if (word_r == (WORD_W+1)'(WORDS - 1)) begin
            word_r <= '0;
            if (!mf_r) begin
              len_r          <= byte_end[LEN_W-1:0];
              s_len_r[hit_r] <= byte_end[LEN_W-1:0];
            end
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        S_CCHK: begin
          if (len_r == '0 || (ram_rdata & need_mask) != need_mask) begin
            res_r       <= '{ST_WAIT, 2'(hit_r), '0};
            out_valid_r <= 1'b1;
          end else if (word_r + 1'b1 >= need_words) begin
            live_r[hit_r] <= 1'b0;
            res_r       <= '{ST_DONE, 2'(hit_r), len_r};
            out_valid_r <= 1'b1;
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/frt_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// frt_bitmap_ram
// Chunk bitmap store, one 32-bit word per address, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module frt_bitmap_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/frt_checker.sv =====
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks on the tracker's request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_fragment_reassembly_tracker_assert.svh"
module frt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [1:0] out_slot_index,
  input wire logic [13:0] out_dgram_len
);
  import frt_pkg::*;

  logic        in_fire;
  logic        out_stall;
  logic        res_done;
  logic        res_other;
  logic        done_len_ok;
  logic [18:0] out_word;

  assign in_fire     = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign res_done    = out_valid && out_status == ST_DONE;
  assign res_other   = out_valid && out_status != ST_DONE;
  assign done_len_ok = out_dgram_len != 14'd0 && out_dgram_len <= 14'(BUF_BYTES);
  assign out_word    = {out_status, out_slot_index, out_dgram_len};

  `FRT_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status <= ST_AGED, "bad status")
  `FRT_ASSERT_IMP(a_len_only_done, clk, rst_n, res_other, out_dgram_len == 14'd0, "stray length")
  `FRT_ASSERT_IMP(a_done_len, clk, rst_n, res_done, done_len_ok, "bad completion length")
  `FRT_ASSERT_NXT(a_one_result, clk, rst_n, in_fire, !in_ready, "request taken while busy")
  `FRT_ASSERT_NXT(a_hold, clk, rst_n, out_stall, out_valid && $stable(out_word), "result lost")
endmodule

bind ipv4_fragment_reassembly_tracker frt_checker u_frt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_slot_index (out_ch.slot_index),
  .out_dgram_len  (out_ch.dgram_len)
);
`default_nettype wire
